// ===== hdl/tlc_pkg.sv =====
package tlc_pkg;

	// Coordinate format and the number of coordinate fields carried per word.
	localparam int COORD_BITS = 16;
	localparam int IN_COORDS  = 7;
	localparam int IN_DATA_W  = IN_COORDS * COORD_BITS;

	// Index into the coordinate fields of one point.
	localparam int JW = 3;

	// Squared difference and accumulated distance widths.
	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int ACC_W = SQ_W + 3;

	// Configuration register widths.
	localparam int RADIUS_W  = 35;
	localparam int DIMS_W    = 3;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 35;

	// Configuration register map.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS_SQ = 8'd0,
		REG_DIMS_USED = 8'd1
	} cfg_reg_t;

	// Read request issued to the distance pipeline, one coordinate word per cycle.
	typedef struct packed {
		logic rd_en;
		logic first;
		logic last;
	} scan_req_t;

	// Status returned by the distance pipeline.
	typedef struct packed {
		logic busy;
		logic hit;
	} scan_sts_t;

endpackage

// ===== hdl/tlc_scan.sv =====
module tlc_scan #(
	parameter int MAX_CENTERS = 1024,
	parameter int DIMS        = 7,
	localparam int DEPTH      = MAX_CENTERS * DIMS,
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tlc_pkg::scan_req_t             req,
	input  logic [AW-1:0]                  rd_addr,
	input  logic [tlc_pkg::COORD_BITS-1:0] pt_coord,
	input  logic                           wr_en,
	input  logic [AW-1:0]                  wr_addr,
	input  logic [tlc_pkg::COORD_BITS-1:0] wr_data,
	input  logic [tlc_pkg::RADIUS_W-1:0]   radius_sq,
	output tlc_pkg::scan_sts_t             sts
);
	import tlc_pkg::*;

	logic [COORD_BITS-1:0]        mem [DEPTH];
	logic [COORD_BITS-1:0]        rdata_s1;
	logic [COORD_BITS-1:0]        pt_s1;
	logic                         v_s1;
	logic                         first_s1;
	logic                         last_s1;
	logic [SQ_W-1:0]              sq_s2;
	logic                         v_s2;
	logic                         first_s2;
	logic                         last_s2;
	logic [ACC_W-1:0]             acc_q;
	logic                         hit_s3;
	logic signed [COORD_BITS:0]   diff;
	logic signed [2*COORD_BITS+1:0] prod;
	logic [ACC_W-1:0]             acc_nxt;
	logic                         flush;

	// Center store: one write port for new centers, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// A hit ends the scan, so everything still in flight is dropped.
	assign flush = hit_s3;

	// Difference of one coordinate against the stored word, then its square.
	assign diff = signed'({pt_s1[COORD_BITS-1], pt_s1}) - signed'({rdata_s1[COORD_BITS-1], rdata_s1});
	assign prod = diff * diff;

	// Running sum over the coordinates of one center, restarted on its first word.
	assign acc_nxt = (first_s2 ? '0 : acc_q) + ACC_W'(sq_s2);

	// Stage valids and the hit flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			hit_s3 <= 1'b0;
		end else begin
			v_s1   <= req.rd_en & ~flush;
			v_s2   <= v_s1 & ~flush;
			hit_s3 <= v_s2 & last_s2 & ~flush & (acc_nxt <= ACC_W'(radius_sq));
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		first_s1 <= req.first;
		last_s1  <= req.last;
		pt_s1    <= pt_coord;
		sq_s2    <= prod[SQ_W-1:0];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		if (v_s2) begin
			acc_q <= acc_nxt;
		end
	end

	assign sts.busy = v_s1 | v_s2;
	assign sts.hit  = hit_s3;

endmodule

// ===== hdl/threshold_leader_clustering.sv =====
// Channel   Direction  Signals                              Word
// s_*       in         s_tvalid s_tready s_tdata s_tuser    one point
// m_*       out        m_tvalid m_tready m_tdata m_tuser    one new center or overflow point
// cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  one register write
//
// An uncovered point is compared with each of the count stored centers over its nd compared
// dimensions, and its DIMS coordinates are written when it is stored. The single read port of
// the center store, one coordinate word per cycle, paces that scan.
// A covered point ends as soon as its hit leaves the distance pipeline.
// Reset clears the center count and the registers; the store itself needs no clearing pass.
// A new point is taken while a result still waits in the output register; a stalled output
// holds the block only when the next result is ready to load.
module threshold_leader_clustering #(
	parameter int MAX_CENTERS = 1024,
	parameter int DIMS        = 7,
	localparam int CW         = $clog2(MAX_CENTERS + 1),
	localparam int OUT_W      = ((CW + tlc_pkg::IN_DATA_W + 7) / 8) * 8,
	localparam int DEPTH      = MAX_CENTERS * DIMS,
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tlc_pkg::IN_DATA_W-1:0]   s_tdata,   // coord_0 .. coord_6, 16 bits each
	input  logic [0:0]                      s_tuser,   // first_point
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [OUT_W-1:0]                m_tdata,   // center_index, out_0 .. out_6, zero pad
	output logic [0:0]                      m_tuser,   // store_full
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tlc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tlc_pkg::CFG_DAT_W-1:0]   cfg_data
);
	import tlc_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_START = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_UNCOV = 6'b010000,
		ST_WRITE = 6'b100000
	} state_t;

	state_t                state_q;
	logic [RADIUS_W-1:0]   radius_q;
	logic [DIMS_W-1:0]     dims_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         c_q;
	logic [AW-1:0]         wbase_q;
	logic [AW-1:0]         cbase_q;
	logic [JW-1:0]         j_q;
	logic [COORD_BITS-1:0] point_q [IN_COORDS];
	logic                  m_tvalid_q;
	logic [CW-1:0]         out_idx_q;
	logic [COORD_BITS-1:0] out_crd_q [IN_COORDS];
	logic                  out_full_q;
	logic [DIMS_W-1:0]     nd;
	logic [DIMS_W-1:0]     nd_last;
	logic                  full;
	logic                  in_acc;
	logic                  out_load;
	logic [COORD_BITS-1:0] pt_sel;
	scan_req_t             req;
	scan_sts_t             sts;

	// Compared dimensions, capped at the stored ones.
	assign nd      = (dims_q < DIMS_W'(DIMS)) ? dims_q : DIMS_W'(DIMS);
	assign nd_last = nd - 1'b1;
	assign full    = count_q >= CW'(MAX_CENTERS);

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_UNCOV) & (~m_tvalid_q | m_tready);
	assign pt_sel    = point_q[j_q];

	// One coordinate word is read per scan cycle, unless a hit has just come back.
	assign req.rd_en = (state_q == ST_SCAN) & ~sts.hit;
	assign req.first = (j_q == '0);
	assign req.last  = (j_q == nd_last);

	tlc_scan #(
		.MAX_CENTERS (MAX_CENTERS),
		.DIMS        (DIMS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rd_addr   (cbase_q + AW'(j_q)),
		.pt_coord  (pt_sel),
		.wr_en     (state_q == ST_WRITE),
		.wr_addr   (wbase_q + AW'(j_q)),
		.wr_data   (pt_sel),
		.radius_sq (radius_q),
		.sts       (sts)
	);

	// Control: registers, center count and the point sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			radius_q   <= '0;
			dims_q     <= DIMS_W'(7);
			count_q    <= '0;
			c_q        <= '0;
			wbase_q    <= '0;
			cbase_q    <= '0;
			j_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_RADIUS_SQ) begin
					radius_q <= cfg_data[RADIUS_W-1:0];
				end else if (cfg_index == REG_DIMS_USED) begin
					dims_q <= cfg_data[DIMS_W-1:0];
				end
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_START;
						if (s_tuser[0]) begin
							count_q <= '0;
							wbase_q <= '0;
						end
					end
				end
				ST_START: begin
					c_q     <= '0;
					cbase_q <= '0;
					j_q     <= '0;
					if (count_q == '0) begin
						state_q <= ST_UNCOV;
					end else if (nd == '0) begin
						// No coordinate compared: every distance is zero, so the point is covered.
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.hit) begin
						state_q <= ST_IDLE;
					end else if (j_q == nd_last) begin
						j_q     <= '0;
						c_q     <= c_q + 1'b1;
						cbase_q <= cbase_q + AW'(DIMS);
						if (c_q == count_q - 1'b1) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (sts.hit) begin
						state_q <= ST_IDLE;
					end else if (!sts.busy) begin
						state_q <= ST_UNCOV;
					end
				end
				ST_UNCOV: begin
					if (out_load) begin
						j_q     <= '0;
						state_q <= full ? ST_IDLE : ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (j_q == JW'(DIMS - 1)) begin
						count_q <= count_q + 1'b1;
						wbase_q <= wbase_q + AW'(DIMS);
						state_q <= ST_IDLE;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Point and result payloads.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int j = 0; j < IN_COORDS; j++) begin
				point_q[j] <= s_tdata[j*COORD_BITS +: COORD_BITS];
			end
		end
		if (out_load) begin
			out_idx_q  <= full ? CW'(MAX_CENTERS) : count_q;
			out_full_q <= full;
			for (int j = 0; j < IN_COORDS; j++) begin
				out_crd_q[j] <= (j < DIMS) ? point_q[j] : '0;
			end
		end
	end

	// Result word packing.
	always_comb begin
		m_tdata         = '0;
		m_tdata[CW-1:0] = out_idx_q;
		for (int j = 0; j < IN_COORDS; j++) begin
			m_tdata[CW + j*COORD_BITS +: COORD_BITS] = out_crd_q[j];
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tuser[0] = out_full_q;

endmodule
